// ----- hdl/rvc_pkg.sv -----
// rvc_pkg: shared types and constants for the repeated value counter
// no dependencies; used by every other file of the block
package rvc_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef struct packed {
      logic                        mark;
      logic signed [VALUE_W-1:0]   value;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_FINISH
   } state_type;

endpackage

// ----- hdl/rvc_req_if.sv -----
// rvc_req_if: input channel, one list element per word
// depends on rvc_pkg for field widths
interface rvc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rvc_pkg::VALUE_W-1:0]  element_value;
   logic                                last_element;

   modport source (output valid, element_value, last_element, input ready);
   modport sink   (input valid, element_value, last_element, output ready);
endinterface

// ----- hdl/rvc_rsp_if.sv -----
// rvc_rsp_if: result channel, one word per finished list
// depends on rvc_pkg for field widths
interface rvc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rvc_pkg::COUNT_W-1:0]   repeat_count;
   logic                          store_overflow;

   modport source (output valid, repeat_count, store_overflow, input ready);
   modport sink   (input valid, repeat_count, store_overflow, output ready);
endinterface

// ----- hdl/rvc_store.sv -----
// rvc_store: value store, one write port and one read port with registered data
// depends on rvc_pkg for the entry type
module rvc_store #(
   parameter int MAX_ELEMENTS = 128
) (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [$clog2(MAX_ELEMENTS)-1:0]  rd_addr,
   output rvc_pkg::entry_type               rd_entry,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_ELEMENTS)-1:0]  wr_addr,
   input  rvc_pkg::entry_type               wr_entry
);

   rvc_pkg::entry_type mem [MAX_ELEMENTS];
   rvc_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- hdl/rvc_ctrl.sv -----
// rvc_ctrl: scan sequencer, fill count, repeat total and result register
// depends on rvc_pkg; drives the read and write ports of rvc_store
module rvc_ctrl #(
   parameter int MAX_ELEMENTS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rvc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rvc_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_overflow,
   output logic                                rd_en,
   output logic [$clog2(MAX_ELEMENTS)-1:0]     rd_addr,
   input  rvc_pkg::entry_type                  rd_entry,
   output logic                                wr_en,
   output logic [$clog2(MAX_ELEMENTS)-1:0]     wr_addr,
   output rvc_pkg::entry_type                  wr_entry
);

   localparam int IDX_W  = $clog2(MAX_ELEMENTS);
   localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_ELEMENTS);

   rvc_pkg::state_type                 state_ff, state_in;
   logic signed [rvc_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               last_ff, last_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;
   logic [FILL_W-1:0]                  issue_ff, issue_in;
   logic [rvc_pkg::COUNT_W-1:0]        total_ff, total_in;
   logic                               ovf_ff, ovf_in;
   logic                               rd_valid_ff;
   logic [IDX_W-1:0]                   cmp_idx_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rvc_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;
   logic                               match;
   logic                               scan_end;
   logic                               rsp_load;

   assign match    = rd_valid_ff && (rd_entry.value == value_ff);
   assign scan_end = rd_valid_ff && !match
                     && (FILL_W'(cmp_idx_ff) == (fill_ff - FILL_W'(1)));

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_load     = 1'b0;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cmp_idx_ff;
      wr_entry     = '{mark: 1'b1, value: value_ff};

      unique case (state_ff)
         rvc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in = req_value;
               last_in  = req_last;
               issue_in = '0;
               state_in = (fill_ff == '0) ? rvc_pkg::ST_INSERT : rvc_pkg::ST_SCAN;
            end
         end
         rvc_pkg::ST_SCAN: begin
            rd_en = (issue_ff < fill_ff) && !match;
            if (rd_en) begin
               issue_in = issue_ff + FILL_W'(1);
            end
            if (match) begin
               if (!rd_entry.mark) begin
                  wr_en = 1'b1;
                  if (total_ff != rvc_pkg::COUNT_MAX) begin
                     total_in = total_ff + rvc_pkg::COUNT_W'(1);
                  end
               end
               state_in = rvc_pkg::ST_FINISH;
            end else if (scan_end) begin
               state_in = rvc_pkg::ST_INSERT;
            end
         end
         rvc_pkg::ST_INSERT: begin
            if (fill_ff == FILL_FULL) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = fill_ff[IDX_W-1:0];
               wr_entry = '{mark: 1'b0, value: value_ff};
               fill_in  = fill_ff + FILL_W'(1);
            end
            state_in = rvc_pkg::ST_FINISH;
         end
         rvc_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = rvc_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_count_in = total_ff;
               rsp_ovf_in   = ovf_ff;
               fill_in      = '0;
               total_in     = '0;
               ovf_in       = 1'b0;
               state_in     = rvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rvc_pkg::ST_IDLE;
         end
      endcase

      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rvc_pkg::ST_IDLE;
         fill_ff      <= '0;
         issue_ff     <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (rd_en) begin
         cmp_idx_ff <= rd_addr;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (fill_ff == FILL_FULL))
      else $error("overflow flagged with free entries");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && state_ff == rvc_pkg::ST_SCAN) |-> (FILL_W'(cmp_idx_ff) < fill_ff))
      else $error("compare on entry past fill count");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (fill_ff == '0 && total_ff == '0 && !ovf_ff && rsp_valid_ff))
      else $error("list state not cleared after result");

endmodule

// ----- hdl/repeated_value_counter_core.sv -----
// repeated_value_counter_core: top level, counts distinct values seen twice or more per list
// depends on rvc_pkg, rvc_req_if, rvc_rsp_if, rvc_store, rvc_ctrl
//
//   channel   dir   word
//   req_bus   in    element_value, last_element
//   rsp_bus   out   repeat_count, store_overflow (one word per list)
//
// each element is compared against the stored values one entry after another, through
// the single read port of the value store; an empty store is not scanned, a hit stops the scan
// synchronous active-high reset clears the fill count, so no store clearing pass
// a waiting result word does not stall input; only the final element of the
// next list waits until the result register is free
module repeated_value_counter_core #(
   parameter int MAX_ELEMENTS = 128
) (
   input  logic       clock,
   input  logic       reset,
   rvc_req_if.sink    req_bus,
   rvc_rsp_if.source  rsp_bus
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   rvc_pkg::entry_type rd_entry;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   rvc_pkg::entry_type wr_entry;

   rvc_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_bus.ready),
      .req_value    (req_bus.element_value),
      .req_last     (req_bus.last_element),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_count    (rsp_bus.repeat_count),
      .rsp_overflow (rsp_bus.store_overflow),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_entry     (rd_entry),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_entry     (wr_entry)
   );

   rvc_store #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_store (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

endmodule

// ----- test/repeated_value_counter_core_test.sv -----
// repeated_value_counter_core_test: self-checking testbench for the repeated value counter
// predicts the count and overflow flag of each list and checks every result word
// depends on rvc_pkg, rvc_req_if, rvc_rsp_if and repeated_value_counter_core
module repeated_value_counter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ELEMENTS = 128;
   localparam int IDLE_LIMIT = 4000;
   localparam int ITEM_TARGET = 1200;

   typedef logic signed [rvc_pkg::VALUE_W-1:0] word_list_type[$];

   typedef struct {
      logic [rvc_pkg::COUNT_W-1:0] repeat_count;
      logic                        store_overflow;
   } list_result_type;

   logic clock;
   logic reset;

   rvc_req_if req_bus ();
   rvc_rsp_if rsp_bus ();

   repeated_value_counter_core #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic signed [rvc_pkg::VALUE_W-1:0] known_values[MAX_ELEMENTS];
   bit                                 repeat_seen[MAX_ELEMENTS];
   int                                 fill_count;
   logic [rvc_pkg::COUNT_W-1:0]        dup_total;
   bit                                 lost_value;
   list_result_type                    awaited_results[$];

   int mismatch_count;
   int elements_sent;
   int idle_cycles;
   int hold_request;
   int hold_left;
   int stall_left;
   bit calm;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [rvc_pkg::VALUE_W-1:0] random_word();
      unique case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // odd multiplier is a bijection, so distinct indexes give distinct values
   function automatic logic signed [rvc_pkg::VALUE_W-1:0] spread_value(logic [31:0] base,
                                                                       int index);
      return base ^ (32'(index) * 32'h9E37_79B1);
   endfunction

   function automatic void absorb_element(logic signed [rvc_pkg::VALUE_W-1:0] value,
                                          logic last);
      bit              found;
      list_result_type result;
      found = 1'b0;
      for (int slot = 0; slot < fill_count; slot++) begin
         if (!found && known_values[slot] == value) begin
            found = 1'b1;
            if (!repeat_seen[slot]) begin
               repeat_seen[slot] = 1'b1;
               if (dup_total != rvc_pkg::COUNT_MAX) dup_total++;
            end
         end
      end
      if (!found) begin
         if (fill_count < MAX_ELEMENTS) begin
            known_values[fill_count] = value;
            repeat_seen[fill_count] = 1'b0;
            fill_count++;
         end else begin
            lost_value = 1'b1;
         end
      end
      if (last) begin
         result.repeat_count = dup_total;
         result.store_overflow = lost_value;
         awaited_results.push_back(result);
         fill_count = 0;
         dup_total = '0;
         lost_value = 1'b0;
      end
   endfunction

   task automatic note_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic send_element(input logic signed [rvc_pkg::VALUE_W-1:0] value,
                               input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.element_value = value;
      req_bus.last_element = last;
      do @(posedge clock); while (!req_bus.ready);
      absorb_element(value, last);
      elements_sent++;
      @(negedge clock);
   endtask

   task automatic send_list(input word_list_type items);
      foreach (items[i]) send_element(items[i], i == items.size() - 1);
   endtask

   task automatic test_single_element();
      send_list({32'h8000_0000});
      send_list({32'h7FFF_FFFF});
   endtask

   task automatic test_extreme_values();
      send_list({32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h5555_5555});
   endtask

   task automatic test_store_overflow();
      word_list_type items;
      logic [31:0]   base;
      base = $urandom();
      for (int i = 0; i < MAX_ELEMENTS; i++) items.push_back(spread_value(base, i));
      items.push_back(spread_value(base, 1000));
      items.push_back(spread_value(base, 1000));
      items.push_back(spread_value(base, 5));
      items.push_back(spread_value(base, 7));
      send_list(items);
   endtask

   task automatic test_count_saturation();
      word_list_type items;
      logic [31:0]   base;
      base = $urandom();
      for (int i = 0; i < MAX_ELEMENTS; i++) items.push_back(spread_value(base, i));
      for (int i = MAX_ELEMENTS - 1; i >= 0; i--) items.push_back(spread_value(base, i));
      send_list(items);
   endtask

   task automatic test_backpressure();
      word_list_type items;
      calm = 1'b1;
      hold_request = 400;
      for (int n = 0; n < 6; n++) begin
         items.delete();
         for (int k = 0; k < 4; k++) items.push_back($signed($urandom_range(0, 3)));
         send_list(items);
      end
      calm = 1'b0;
   endtask

   task automatic test_random_lists();
      int                                 target;
      int                                 len;
      int                                 mode;
      int                                 pool_size;
      int                                 fresh;
      logic [31:0]                        base;
      logic signed [rvc_pkg::VALUE_W-1:0] pool[6];
      word_list_type                      items;
      target = ITEM_TARGET;
      while (elements_sent < target) begin
         calm = ($urandom_range(0, 4) == 0);
         mode = $urandom_range(0, 99);
         items.delete();
         if (mode < 2) begin
            len = $urandom_range(100, 180);
            base = $urandom();
            fresh = 0;
            for (int k = 0; k < len; k++) begin
               if (fresh > 0 && $urandom_range(0, 3) == 0) begin
                  items.push_back(spread_value(base, $urandom_range(0, fresh - 1)));
               end else begin
                  items.push_back(spread_value(base, fresh));
                  fresh++;
               end
            end
         end else begin
            len = $urandom_range(1, 16);
            pool_size = $urandom_range(1, 6);
            foreach (pool[k]) pool[k] = random_word();
            for (int k = 0; k < len; k++) begin
               if (mode < 62) items.push_back(pool[$urandom_range(0, pool_size - 1)]);
               else if (mode < 82) items.push_back($urandom());
               else items.push_back($signed($urandom_range(0, 15)) - 8);
            end
         end
         send_list(items);
      end
      calm = 1'b0;
   endtask

   // result side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("result word with no list pending");
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.repeat_count !== want.repeat_count)
               note_mismatch($sformatf("repeat_count %0d, want %0d",
                                       rsp_bus.repeat_count, want.repeat_count));
            if (rsp_bus.store_overflow !== want.store_overflow)
               note_mismatch($sformatf("store_overflow %b, want %b",
                                       rsp_bus.store_overflow, want.store_overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.element_value = '0;
      req_bus.last_element = 1'b0;
      rsp_bus.ready = 1'b0;
      calm = 1'b0;
      hold_request = 0;
      hold_left = 0;
      stall_left = 0;
      mismatch_count = 0;
      elements_sent = 0;
      idle_cycles = 0;
      fill_count = 0;
      dup_total = '0;
      lost_value = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_element();
      test_extreme_values();
      test_store_overflow();
      test_count_saturation();
      test_backpressure();
      test_random_lists();

      req_bus.valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (MAX_ELEMENTS + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
